// ===== hw/rtl/dmhq_pkg.sv =====
package dmhq_pkg;

	localparam int DEF_ARITY     = 4;
	localparam int DEF_CAPACITY  = 1024;
	localparam int DEF_KEY_BITS  = 32;
	localparam int DEF_NODE_BITS = 16;

	localparam int OPC_W   = 2;
	localparam int KEYIO_W = 32;
	localparam int NODEIO_W = 16;
	localparam int COUNT_W = 11;
	localparam int STAT_W  = 2;

	typedef enum logic [OPC_W-1:0] {
		OP_INSERT  = 2'd0,
		OP_EXTRACT = 2'd1,
		OP_CLEAR   = 2'd2
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [OPC_W-1:0]    opcode;
		logic [NODEIO_W-1:0] node_id;
		logic [KEYIO_W-1:0]  key_in;
	} cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0]   status;
		logic [KEYIO_W-1:0]  key_out;
		logic [NODEIO_W-1:0] node_out;
		logic [COUNT_W-1:0]  entry_count;
		logic                heap_empty;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_IDX,
		S_UP_RD,
		S_UP_CMP,
		S_EX_ROOT,
		S_EX_LAST,
		S_DN_IDX,
		S_DN_CHK,
		S_DN_SCAN,
		S_DN_CMP,
		S_FIN
	} state_t;

endpackage

// ===== hw/rtl/dmhq_ram.sv =====
module dmhq_ram import dmhq_pkg::*; #(
	parameter int WIDTH = DEF_KEY_BITS + DEF_NODE_BITS,
	parameter int DEPTH = DEF_CAPACITY
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/dmhq_idx.sv =====
module dmhq_idx import dmhq_pkg::*; #(
	parameter int ARITY    = DEF_ARITY,
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic                                             clk,
	input  logic [$clog2(CAPACITY)-1:0]                      pos,
	output logic [$clog2(CAPACITY)-1:0]                      parent_q,
	output logic [$clog2(CAPACITY)+$clog2(ARITY):0]          first_q
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int LG    = $clog2(ARITY);
	localparam int FC_W  = IDX_W + LG + 1;
	localparam int SH    = IDX_W + LG;
	localparam int PW    = 2 * IDX_W + 2;
	localparam longint unsigned RECIP = ((64'd1 << SH) + ARITY - 1) / ARITY;

	logic [IDX_W-1:0] pm1;
	logic [PW-1:0]    prod;
	logic [FC_W-1:0]  first_d;

	// floor((pos - 1) / ARITY) by reciprocal multiply, exact over the index range
	always_comb begin
		pm1     = pos - IDX_W'(1);
		prod    = PW'(pm1) * PW'(RECIP);
		first_d = FC_W'(pos) * FC_W'(ARITY) + FC_W'(1);
	end

	always_ff @(posedge clk) begin
		parent_q <= IDX_W'(prod >> SH);
		first_q  <= first_d;
	end

endmodule

// ===== hw/rtl/dmhq_engine.sv =====
module dmhq_engine import dmhq_pkg::*; #(
	parameter int ARITY     = DEF_ARITY,
	parameter int CAPACITY  = DEF_CAPACITY,
	parameter int KEY_BITS  = DEF_KEY_BITS,
	parameter int NODE_BITS = DEF_NODE_BITS
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  cmd_t                                    cmd,
	output logic                                    busy,
	output logic                                    done,
	output rsp_t                                    result,
	output logic [$clog2(CAPACITY)-1:0]             pos,
	input  logic [$clog2(CAPACITY)-1:0]             parent,
	input  logic [$clog2(CAPACITY)+$clog2(ARITY):0] first,
	output logic                                    we,
	output logic [$clog2(CAPACITY)-1:0]             waddr,
	output logic [KEY_BITS+NODE_BITS-1:0]           wdata,
	output logic                                    re,
	output logic [$clog2(CAPACITY)-1:0]             raddr,
	input  logic [KEY_BITS+NODE_BITS-1:0]           rdata
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int FC_W  = IDX_W + $clog2(ARITY) + 1;
	localparam int ENT_W = KEY_BITS + NODE_BITS;

	state_t state_q, state_d;

	logic [CNT_W-1:0]     fill_q;
	logic [IDX_W-1:0]     pos_q;
	logic [ENT_W-1:0]     mov_q;
	logic [ENT_W-1:0]     best_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [IDX_W-1:0]     rd_addr_q;
	logic [IDX_W-1:0]     last_q;
	logic                 scan_first_q;
	logic [STAT_W-1:0]    st_q;
	logic [KEY_BITS-1:0]  okey_q;
	logic [NODE_BITS-1:0] onode_q;
	logic                 done_q;
	rsp_t                 result_q;

	logic [KEY_BITS-1:0]         mov_key, best_key, rd_key;
	logic [KEY_BITS+KEYIO_W-1:0] key_ext, okey_ext;
	logic [NODE_BITS+NODEIO_W-1:0] onode_ext;
	logic [CNT_W+COUNT_W-1:0]    cnt_ext;
	logic                        full, first_out;
	logic [FC_W-1:0]             last_c, last_lim;
	logic [IDX_W-1:0]            last_d;

	always_comb begin
		mov_key   = mov_q[ENT_W-1:NODE_BITS];
		best_key  = best_q[ENT_W-1:NODE_BITS];
		rd_key    = rdata[ENT_W-1:NODE_BITS];
		key_ext   = {{KEY_BITS{1'b0}}, cmd.key_in};
		okey_ext  = {{KEYIO_W{1'b0}}, okey_q};
		onode_ext = {{NODEIO_W{1'b0}}, onode_q};
		cnt_ext   = {{COUNT_W{1'b0}}, fill_q};
		full      = (fill_q >= CNT_W'(CAPACITY));
		first_out = (first >= FC_W'(fill_q));
		last_c    = first + FC_W'(ARITY - 1);
		last_lim  = FC_W'(fill_q) - FC_W'(1);
		last_d    = (last_c > last_lim) ? last_lim[IDX_W-1:0] : last_c[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = pos_q;
		wdata   = mov_q;
		re      = 1'b0;
		raddr   = parent;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (cmd.opcode)
						OP_INSERT: begin
							state_d = full ? S_FIN : S_UP_IDX;
						end
						OP_EXTRACT: begin
							if (fill_q == '0) begin
								state_d = S_FIN;
							end else begin
								re      = 1'b1;
								raddr   = '0;
								state_d = S_EX_ROOT;
							end
						end
						default: begin
							state_d = S_FIN;
						end
					endcase
				end
			end
			S_EX_ROOT: begin
				re      = 1'b1;
				raddr   = IDX_W'(fill_q - CNT_W'(1));
				state_d = S_EX_LAST;
			end
			S_EX_LAST: begin
				state_d = S_DN_IDX;
			end
			S_DN_IDX: begin
				state_d = S_DN_CHK;
			end
			S_DN_CHK: begin
				if (first_out) begin
					we      = 1'b1;
					state_d = S_FIN;
				end else begin
					re      = 1'b1;
					raddr   = first[IDX_W-1:0];
					state_d = S_DN_SCAN;
				end
			end
			S_DN_SCAN: begin
				if (rd_addr_q == last_q) begin
					state_d = S_DN_CMP;
				end else begin
					re    = 1'b1;
					raddr = rd_addr_q + IDX_W'(1);
				end
			end
			S_DN_CMP: begin
				we = 1'b1;
				if (mov_key <= best_key) begin
					state_d = S_FIN;
				end else begin
					wdata   = best_q;
					state_d = S_DN_IDX;
				end
			end
			S_UP_IDX: begin
				if (pos_q == '0) begin
					we      = 1'b1;
					state_d = S_FIN;
				end else begin
					state_d = S_UP_RD;
				end
			end
			S_UP_RD: begin
				re      = 1'b1;
				state_d = S_UP_CMP;
			end
			S_UP_CMP: begin
				we = 1'b1;
				if (rd_key > mov_key) begin
					wdata   = rdata;
					state_d = S_UP_IDX;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == S_FIN);
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (cmd.opcode)
							OP_INSERT: begin
								if (!full) begin
									fill_q <= fill_q + CNT_W'(1);
								end
							end
							OP_CLEAR: begin
								fill_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_EX_ROOT: begin
					fill_q <= fill_q - CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					okey_q  <= '0;
					onode_q <= '0;
					pos_q   <= IDX_W'(fill_q);
					mov_q   <= {key_ext[KEY_BITS-1:0], cmd.node_id[NODE_BITS-1:0]};
					if (cmd.opcode == OP_INSERT && full) begin
						st_q <= ST_FULL;
					end else if (cmd.opcode == OP_EXTRACT && fill_q == '0) begin
						st_q <= ST_EMPTY;
					end else begin
						st_q <= ST_OK;
					end
				end
			end
			S_EX_ROOT: begin
				okey_q  <= rd_key;
				onode_q <= rdata[NODE_BITS-1:0];
			end
			S_EX_LAST: begin
				mov_q <= rdata;
				pos_q <= '0;
			end
			S_DN_CHK: begin
				rd_addr_q    <= first[IDX_W-1:0];
				last_q       <= last_d;
				scan_first_q <= 1'b1;
			end
			S_DN_SCAN: begin
				scan_first_q <= 1'b0;
				if (scan_first_q || rd_key < best_key) begin
					best_q     <= rdata;
					best_idx_q <= rd_addr_q;
				end
				if (rd_addr_q != last_q) begin
					rd_addr_q <= rd_addr_q + IDX_W'(1);
				end
			end
			S_DN_CMP: begin
				pos_q <= best_idx_q;
			end
			S_UP_CMP: begin
				pos_q <= parent;
			end
			S_FIN: begin
				result_q.status      <= st_q;
				result_q.key_out     <= okey_ext[KEYIO_W-1:0];
				result_q.node_out    <= onode_ext[NODEIO_W-1:0];
				result_q.entry_count <= cnt_ext[COUNT_W-1:0];
				result_q.heap_empty  <= (fill_q == '0);
			end
			default: begin
			end
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;
	assign pos    = pos_q;

endmodule

// ===== hw/rtl/dary_min_heap_queue_top.sv =====
// channel   | handshake                  | payload
// ----------+----------------------------+------------------------------------
// request   | start high while busy low  | cmd (opcode, node_id, key_in)
// result    | done strobe, one cycle     | result (status, key_out, node_out,
//           |                            |   entry_count, heap_empty)
//
// one request at a time; busy drops in the cycle that strobes its result
// insert: index, parent read and compare per level, until it reaches the root or stops
// extract: root and last reads, then index, check, a scan of up to ARITY children
//   and compare per level; clear, error and no-op requests go straight to finish
// reset clears the fill count, state and done flag; the store needs no clearing pass
// the receiver cannot stall: done lasts exactly one cycle
module dary_min_heap_queue_top import dmhq_pkg::*; #(
	parameter int ARITY     = DEF_ARITY,
	parameter int CAPACITY  = DEF_CAPACITY,
	parameter int KEY_BITS  = DEF_KEY_BITS,
	parameter int NODE_BITS = DEF_NODE_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  cmd_t cmd,
	output logic busy,
	output logic done,
	output rsp_t result
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int FC_W  = IDX_W + $clog2(ARITY) + 1;
	localparam int ENT_W = KEY_BITS + NODE_BITS;

	logic [IDX_W-1:0] pos, parent, waddr, raddr;
	logic [FC_W-1:0]  first;
	logic             we, re;
	logic [ENT_W-1:0] wdata, rdata;

	dmhq_idx #(
		.ARITY    (ARITY),
		.CAPACITY (CAPACITY)
	) u_idx (
		.clk      (clk),
		.pos      (pos),
		.parent_q (parent),
		.first_q  (first)
	);

	dmhq_ram #(
		.WIDTH (ENT_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	dmhq_engine #(
		.ARITY     (ARITY),
		.CAPACITY  (CAPACITY),
		.KEY_BITS  (KEY_BITS),
		.NODE_BITS (NODE_BITS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result),
		.pos    (pos),
		.parent (parent),
		.first  (first),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.re     (re),
		.raddr  (raddr),
		.rdata  (rdata)
	);

endmodule

// ===== hw/rtl/dmhq_checker.sv =====
module dmhq_checker import dmhq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input cmd_t cmd,
	input logic busy,
	input logic done,
	input rsp_t result
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.heap_empty == (result.entry_count == '0))
		else $error("heap_empty disagrees with entry_count");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ST_OK |-> result.key_out == '0 && result.node_out == '0)
		else $error("error result carries a payload");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_EMPTY |-> result.entry_count == '0)
		else $error("empty extract with nonzero count");

endmodule

bind dary_min_heap_queue_top dmhq_checker u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.cmd    (cmd),
	.busy   (busy),
	.done   (done),
	.result (result)
);
